// ===== sv/oprc_pkg.sv =====
// Package for the optimal-replacement cache simulator.
// Sizes, field widths, codes and shared types; no dependencies.
package oprc_pkg;

   // Build sizes
   localparam int TRACE_DEPTH = 1024;
   localparam int WAYS        = 16;
   localparam int ADDR_BITS   = 32;

   // Derived widths
   localparam int TIDX_W = $clog2(TRACE_DEPTH);
   localparam int TLEN_W = $clog2(TRACE_DEPTH + 1);
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int FILL_W = $clog2(WAYS + 1);
   localparam int DRN_W  = $clog2(WAYS + 1);

   // Fixed field widths of the channels
   localparam int CFG_W     = 5;
   localparam int IN_ADDR_W = 32;
   localparam int OUT_WAY_W = 4;
   localparam int OUT_IDX_W = 10;
   localparam int CNT_W     = 11;

   // Item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   // Outcome codes
   typedef enum logic [1:0] {
      OUT_HIT  = 2'd0,
      OUT_COMP = 2'd1,
      OUT_CAP  = 2'd2,
      OUT_NONE = 2'd3
   } outcome_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_HIT,
      ST_EARLY,
      ST_DECIDE,
      ST_LATE,
      ST_CHAIN,
      ST_FIN
   } state_type;

   // Trace word moving down the row of cells
   typedef struct packed {
      logic                 vld;
      logic [ADDR_BITS-1:0] word;
      logic [TIDX_W-1:0]    k;
   } scan_type;

   // Victim search token moving down the row of cells
   typedef struct packed {
      logic              active;
      logic              found;
      logic [TIDX_W-1:0] far;
      logic [WAY_W-1:0]  victim;
   } chain_type;

endpackage

// ===== sv/oprc_if.sv =====
// Channel interfaces of the optimal-replacement cache simulator.
// Depends on oprc_pkg for field widths.
interface oprc_req_if import oprc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [IN_ADDR_W-1:0] block_address;
   logic                 start_new;
   modport source (output valid, kind, block_address, start_new, input ready);
   modport sink (input valid, kind, block_address, start_new, output ready);
endinterface

interface oprc_rsp_if import oprc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           outcome;
   logic [OUT_WAY_W-1:0] way_used;
   logic [OUT_IDX_W-1:0] access_index;
   logic [CNT_W-1:0]     hit_count;
   logic [CNT_W-1:0]     compulsory_count;
   logic [CNT_W-1:0]     capacity_count;
   logic                 trace_done;
   modport source (output valid, outcome, way_used, access_index, hit_count,
                   compulsory_count, capacity_count, trace_done, input ready);
   modport sink (input valid, outcome, way_used, access_index, hit_count,
                 compulsory_count, capacity_count, trace_done, output ready);
endinterface

interface oprc_csr_if import oprc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== sv/optimal_replacement_cache_sim.sv =====
// Fully associative cache simulator with optimal (farthest next use)
// replacement. Depends on oprc_pkg, oprc_if, oprc_ram and oprc_cell.
//
// Load beats append addresses to a 1024-entry trace RAM while the
// controller stays idle. A step beat reads its address and probes the
// ways; a miss adds a scan from the trace start for an earlier use
// (stopping at the first match) and, with all ways filled, a forward
// scan over the rest of the trace, a drain of the row of way cells and
// a pass of the victim search token down the row. Both scans use the
// single trace RAM read port. One beat is in work at a time; a
// finished result waits in the output register while the next beat is
// accepted.
module optimal_replacement_cache_sim import oprc_pkg::*; (
   input logic        clock,
   input logic        reset,
   oprc_req_if.sink   req_bus,
   oprc_rsp_if.source rsp_bus,
   oprc_csr_if.sink   csr_bus
);

   state_type            state_ff, state_in;
   logic [TLEN_W-1:0]    len_ff, len_in;
   logic [TLEN_W-1:0]    npos_ff, npos_in;
   logic [TLEN_W-1:0]    ptr_ff, ptr_in;
   logic [FILL_W-1:0]    filled_ff, filled_in;
   logic [CNT_W-1:0]     hits_ff, hits_in;
   logic [CNT_W-1:0]     comps_ff, comps_in;
   logic [CNT_W-1:0]     caps_ff, caps_in;
   logic [CFG_W-1:0]     cfg_ff;
   logic [ADDR_BITS-1:0] a_ff, a_in;
   logic                 rv_ff, rv_in;
   logic [TIDX_W-1:0]    rk_ff, rk_in;
   logic                 found_ff, found_in;
   logic [DRN_W-1:0]     drain_ff, drain_in;
   outcome_type          outcome_ff, outcome_in;
   logic [WAY_W-1:0]     way_ff, way_in;
   logic                 nostep_ff, nostep_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_outcome_ff, rsp_outcome_in;
   logic [OUT_WAY_W-1:0] rsp_way_ff, rsp_way_in;
   logic [OUT_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [CNT_W-1:0]     rsp_hits_ff, rsp_hits_in;
   logic [CNT_W-1:0]     rsp_comps_ff, rsp_comps_in;
   logic [CNT_W-1:0]     rsp_caps_ff, rsp_caps_in;
   logic                 rsp_done_ff, rsp_done_in;

   // trace RAM
   logic                 ram_we;
   logic [TIDX_W-1:0]    ram_waddr, ram_raddr;
   logic [ADDR_BITS-1:0] ram_wdata, ram_rdata;

   // way cells
   logic                 tag_en;
   logic [WAY_W-1:0]     tag_sel;
   logic                 clear_seen;
   logic                 chain_start;
   logic [WAYS-1:0]      hit_vec;
   logic [WAY_W-1:0]     hit_way;
   logic [FILL_W-1:0]    eff_ways;
   logic                 issue;
   scan_type             scan_c  [WAYS+1];
   chain_type            chain_c [WAYS+1];

   localparam logic [DRN_W-1:0] DRAIN_LAST = DRN_W'(WAYS - 1);

   oprc_ram #(.WIDTH(ADDR_BITS), .DEPTH(TRACE_DEPTH)) u_trace (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // row of way cells; trace words and the search token ripple through
   assign scan_c[0].vld  = rv_ff && (state_ff == ST_LATE);
   assign scan_c[0].word = ram_rdata;
   assign scan_c[0].k    = rk_ff;

   assign chain_c[0].active = chain_start;
   assign chain_c[0].found  = 1'b0;
   assign chain_c[0].far    = '0;
   assign chain_c[0].victim = '0;

   for (genvar i = 0; i < WAYS; i++) begin : g_cell
      oprc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .way_idx    (WAY_W'(i)),
         .filled     (FILL_W'(i) < filled_ff),
         .tag_we     (tag_en && (tag_sel == WAY_W'(i))),
         .tag_wdata  (a_ff),
         .clear_seen (clear_seen),
         .probe      (a_ff),
         .hit        (hit_vec[i]),
         .scan_in    (scan_c[i]),
         .scan_out   (scan_c[i+1]),
         .chain_in   (chain_c[i]),
         .chain_out  (chain_c[i+1])
      );
   end

   // encode the hitting way (tags are distinct)
   always_comb begin
      hit_way = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (hit_vec[i]) begin
            hit_way = hit_way | WAY_W'(i);
         end
      end
   end

   // clamp the way count register to 1..WAYS
   always_comb begin
      if (cfg_ff == '0) begin
         eff_ways = FILL_W'(1);
      end else if (CFG_W'(cfg_ff) > CFG_W'(WAYS)) begin
         eff_ways = FILL_W'(WAYS);
      end else begin
         eff_ways = FILL_W'(cfg_ff);
      end
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   // controller
   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      npos_in    = npos_ff;
      ptr_in     = ptr_ff;
      filled_in  = filled_ff;
      hits_in    = hits_ff;
      comps_in   = comps_ff;
      caps_in    = caps_ff;
      a_in       = a_ff;
      rv_in      = 1'b0;
      rk_in      = ptr_ff[TIDX_W-1:0];
      found_in   = found_ff;
      drain_in   = drain_ff;
      outcome_in = outcome_ff;
      way_in     = way_ff;
      nostep_in  = nostep_ff;
      ram_we     = 1'b0;
      ram_waddr  = len_ff[TIDX_W-1:0];
      ram_wdata  = ADDR_BITS'(req_bus.block_address);
      ram_raddr  = ptr_ff[TIDX_W-1:0];
      tag_en     = 1'b0;
      tag_sel    = '0;
      clear_seen = 1'b0;
      chain_start = 1'b0;
      issue      = 1'b0;

      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_way_in     = rsp_way_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_hits_in    = rsp_hits_ff;
      rsp_comps_in   = rsp_comps_ff;
      rsp_caps_in    = rsp_caps_ff;
      rsp_done_in    = rsp_done_ff;

      unique case (state_ff)
         ST_IDLE: begin
            ram_raddr = npos_ff[TIDX_W-1:0];
            if (req_bus.valid) begin
               if (req_bus.kind == KIND_LOAD) begin
                  if (req_bus.start_new) begin
                     ram_we    = 1'b1;
                     ram_waddr = '0;
                     len_in    = TLEN_W'(1);
                     npos_in   = '0;
                     filled_in = '0;
                     hits_in   = '0;
                     comps_in  = '0;
                     caps_in   = '0;
                  end else if (len_ff < TLEN_W'(TRACE_DEPTH)) begin
                     ram_we = 1'b1;
                     len_in = len_ff + TLEN_W'(1);
                  end
               end else if (npos_ff >= len_ff) begin
                  outcome_in = OUT_NONE;
                  way_in     = '0;
                  nostep_in  = 1'b1;
                  state_in   = ST_FIN;
               end else begin
                  nostep_in = 1'b0;
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            a_in     = ram_rdata;
            state_in = ST_HIT;
         end
         ST_HIT: begin
            if (|hit_vec) begin
               outcome_in = OUT_HIT;
               way_in     = hit_way;
               hits_in    = hits_ff + CNT_W'(1);
               state_in   = ST_FIN;
            end else begin
               found_in = 1'b0;
               ptr_in   = '0;
               state_in = ST_EARLY;
            end
         end
         // scan from the trace start for an earlier use of the address
         ST_EARLY: begin
            issue = (ptr_ff < npos_ff);
            rv_in = issue;
            if (issue) begin
               ptr_in = ptr_ff + TLEN_W'(1);
            end
            if (rv_ff && (ram_rdata == a_ff)) begin
               found_in = 1'b1;
               rv_in    = 1'b0;
               state_in = ST_DECIDE;
            end else if (!issue && !rv_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (found_ff) begin
               outcome_in = OUT_CAP;
               caps_in    = caps_ff + CNT_W'(1);
            end else begin
               outcome_in = OUT_COMP;
               comps_in   = comps_ff + CNT_W'(1);
            end
            if (filled_ff < eff_ways) begin
               way_in    = filled_ff[WAY_W-1:0];
               tag_en    = 1'b1;
               tag_sel   = filled_ff[WAY_W-1:0];
               filled_in = filled_ff + FILL_W'(1);
               state_in  = ST_FIN;
            end else if ((npos_ff + TLEN_W'(1)) >= len_ff) begin
               way_in   = '0;
               tag_en   = 1'b1;
               tag_sel  = '0;
               state_in = ST_FIN;
            end else begin
               ptr_in     = npos_ff + TLEN_W'(1);
               clear_seen = 1'b1;
               drain_in   = '0;
               state_in   = ST_LATE;
            end
         end
         // forward scan; words ripple through the cells, then drain
         ST_LATE: begin
            issue = (ptr_ff < len_ff);
            rv_in = issue;
            if (issue) begin
               ptr_in = ptr_ff + TLEN_W'(1);
            end else if (!rv_ff) begin
               drain_in = drain_ff + DRN_W'(1);
               if (drain_ff == DRAIN_LAST) begin
                  chain_start = 1'b1;
                  state_in    = ST_CHAIN;
               end
            end
         end
         ST_CHAIN: begin
            if (chain_c[WAYS].active) begin
               way_in   = chain_c[WAYS].victim;
               tag_en   = 1'b1;
               tag_sel  = chain_c[WAYS].victim;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = outcome_ff;
               rsp_way_in     = OUT_WAY_W'(way_ff);
               rsp_hits_in    = hits_ff;
               rsp_comps_in   = comps_ff;
               rsp_caps_in    = caps_ff;
               if (nostep_ff) begin
                  rsp_idx_in  = '0;
                  rsp_done_in = 1'b1;
               end else begin
                  rsp_idx_in  = OUT_IDX_W'(npos_ff);
                  rsp_done_in = ((npos_ff + TLEN_W'(1)) == len_ff);
                  npos_in     = npos_ff + TLEN_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         npos_ff      <= '0;
         filled_ff    <= '0;
         hits_ff      <= '0;
         comps_ff     <= '0;
         caps_ff      <= '0;
         cfg_ff       <= CFG_W'(16);
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         npos_ff      <= npos_in;
         filled_ff    <= filled_in;
         hits_ff      <= hits_in;
         comps_ff     <= comps_in;
         caps_ff      <= caps_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            cfg_ff <= csr_bus.data;
         end
      end
      ptr_ff         <= ptr_in;
      a_ff           <= a_in;
      rk_ff          <= rk_in;
      found_ff       <= found_in;
      drain_ff       <= drain_in;
      outcome_ff     <= outcome_in;
      way_ff         <= way_in;
      nostep_ff      <= nostep_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_way_ff     <= rsp_way_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_hits_ff    <= rsp_hits_in;
      rsp_comps_ff   <= rsp_comps_in;
      rsp_caps_ff    <= rsp_caps_in;
      rsp_done_ff    <= rsp_done_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.outcome          = rsp_outcome_ff;
   assign rsp_bus.way_used         = rsp_way_ff;
   assign rsp_bus.access_index     = rsp_idx_ff;
   assign rsp_bus.hit_count        = rsp_hits_ff;
   assign rsp_bus.compulsory_count = rsp_comps_ff;
   assign rsp_bus.capacity_count   = rsp_caps_ff;
   assign rsp_bus.trace_done       = rsp_done_ff;

   // cached tags are distinct, so at most one way hits
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HIT) |-> $onehot0(hit_vec))
      else $error("more than one way hit");

   // step position never passes the trace length
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      npos_ff <= len_ff)
      else $error("step position beyond trace length");

   // fill level never exceeds the built ways
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FILL_W'(WAYS))
      else $error("fill level beyond way count");

   // the read pipeline is empty once the victim search runs
   a_scan_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHAIN) |-> !rv_ff)
      else $error("trace read in flight during victim search");

   // a hit bumps the hit total by exactly one
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_HIT) && (|hit_vec)) |=> (hits_ff == $past(hits_ff) + CNT_W'(1)))
      else $error("hit total not advanced");

endmodule

// ===== sv/oprc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oprc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/oprc_cell.sv =====
// One cache way: tag, next-use capture during the forward scan and one
// step of the victim search. Depends on oprc_pkg.
module oprc_cell import oprc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [WAY_W-1:0]     way_idx,
   input  logic                 filled,
   input  logic                 tag_we,
   input  logic [ADDR_BITS-1:0] tag_wdata,
   input  logic                 clear_seen,
   input  logic [ADDR_BITS-1:0] probe,
   output logic                 hit,
   input  scan_type             scan_in,
   output scan_type             scan_out,
   input  chain_type            chain_in,
   output chain_type            chain_out
);

   logic [ADDR_BITS-1:0] tag_ff;
   logic                 seen_ff, seen_in;
   logic [TIDX_W-1:0]    k_ff, k_in;
   scan_type             scan_ff;
   chain_type            chain_ff, chain_in_nx;

   assign hit = filled && (tag_ff == probe);

   // first recurrence of the tag in the later trace
   always_comb begin
      seen_in = seen_ff;
      k_in    = k_ff;
      if (clear_seen) begin
         seen_in = 1'b0;
      end else if (scan_in.vld && !seen_ff && (scan_in.word == tag_ff)) begin
         seen_in = 1'b1;
         k_in    = scan_in.k;
      end
   end

   // victim search step: lowest way never reused, else farthest reuse
   always_comb begin
      chain_in_nx = chain_in;
      if (chain_in.active && filled && !chain_in.found) begin
         if (!seen_ff) begin
            chain_in_nx.found  = 1'b1;
            chain_in_nx.victim = way_idx;
         end else if (k_ff >= chain_in.far) begin
            chain_in_nx.far    = k_ff;
            chain_in_nx.victim = way_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff         <= 1'b0;
         scan_ff.vld     <= 1'b0;
         chain_ff.active <= 1'b0;
      end else begin
         seen_ff         <= seen_in;
         scan_ff.vld     <= scan_in.vld;
         chain_ff.active <= chain_in_nx.active;
      end
      if (tag_we) begin
         tag_ff <= tag_wdata;
      end
      k_ff            <= k_in;
      scan_ff.word    <= scan_in.word;
      scan_ff.k       <= scan_in.k;
      chain_ff.found  <= chain_in_nx.found;
      chain_ff.far    <= chain_in_nx.far;
      chain_ff.victim <= chain_in_nx.victim;
   end

   assign scan_out  = scan_ff;
   assign chain_out = chain_ff;

endmodule

// ===== tb/sv/oprc_scoreboard.sv =====
// Scoreboard for the optimal-replacement cache simulator: a behavioral
// model of the trace, the ways and the counts. Depends on oprc_pkg.
import oprc_pkg::*;

typedef struct packed {
   logic [1:0]           outcome;
   logic [OUT_WAY_W-1:0] way_used;
   logic [OUT_IDX_W-1:0] access_index;
   logic [CNT_W-1:0]     hit_count;
   logic [CNT_W-1:0]     compulsory_count;
   logic [CNT_W-1:0]     capacity_count;
   logic                 trace_done;
} access_report_type;

class belady_scoreboard_type;
   logic [ADDR_BITS-1:0] trace[TRACE_DEPTH];
   int unsigned          trace_len;
   int unsigned          cursor;
   logic [ADDR_BITS-1:0] tags[WAYS];
   int unsigned          filled;
   int unsigned          hits, comps, caps;
   int unsigned          ways_cfg;
   access_report_type    pending_reports[$];
   int unsigned          mismatches;

   function new();
      ways_cfg = 16;
      mismatches = 0;
      clear_all();
   endfunction

   function void clear_all();
      trace_len = 0;
      cursor = 0;
      filled = 0;
      hits = 0;
      comps = 0;
      caps = 0;
   endfunction

   function void set_ways(logic [CFG_W-1:0] v);
      ways_cfg = 32'(v);
   endfunction

   // Farthest next use; lowest way with no future use wins outright
   function int unsigned farthest_way(int unsigned pos);
      int unsigned victim, far;
      bit seen;
      victim = 0;
      far = 0;
      for (int unsigned w = 0; w < filled; w++) begin
         if (pos + 1 >= trace_len) break;
         seen = 0;
         for (int unsigned k = pos + 1; k < trace_len; k++) begin
            if (trace[k] == tags[w]) begin
               seen = 1;
               if (k >= far) begin
                  far = k;
                  victim = w;
               end
               break;
            end
         end
         if (!seen) return w;
      end
      return victim;
   endfunction

   // Note an accepted request beat
   function void note_request(logic kind, logic [IN_ADDR_W-1:0] addr, logic start);
      access_report_type r;
      int unsigned eff, pos, way;
      bit hit, earlier;
      if (kind == KIND_LOAD) begin
         if (start) clear_all();
         if (trace_len < TRACE_DEPTH) begin
            trace[trace_len] = addr;
            trace_len++;
         end
         return;
      end
      r = '0;
      if (cursor >= trace_len) begin
         r.outcome = OUT_NONE;
         r.trace_done = 1'b1;
      end else begin
         pos = cursor;
         hit = 0;
         way = 0;
         for (int unsigned w = 0; w < filled; w++)
            if (tags[w] == trace[pos]) begin
               hit = 1;
               way = w;
               break;
            end
         if (hit) begin
            r.outcome = OUT_HIT;
            hits++;
         end else begin
            earlier = 0;
            for (int unsigned j = 0; j < pos; j++)
               if (trace[j] == trace[pos]) begin
                  earlier = 1;
                  break;
               end
            if (earlier) begin
               r.outcome = OUT_CAP;
               caps++;
            end else begin
               r.outcome = OUT_COMP;
               comps++;
            end
            eff = (ways_cfg < 1) ? 1 : (ways_cfg > WAYS) ? WAYS : ways_cfg;
            if (filled < eff) begin
               way = filled;
               filled++;
            end else begin
               way = farthest_way(pos);
            end
            tags[way] = trace[pos];
         end
         r.way_used = OUT_WAY_W'(way);
         r.access_index = OUT_IDX_W'(pos);
         cursor = pos + 1;
         r.trace_done = (cursor == trace_len);
      end
      r.hit_count = CNT_W'(hits);
      r.compulsory_count = CNT_W'(comps);
      r.capacity_count = CNT_W'(caps);
      pending_reports.insert(pending_reports.size(), r);
   endfunction

   // Check one response beat against the oldest expectation
   function void check_response(access_report_type got);
      access_report_type want;
      if (pending_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response beat %p", got);
         return;
      end
      want = pending_reports.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
      end
   endfunction
endclass

// ===== tb/sv/tb_optimal_replacement_cache_sim.sv =====
// Top-level testbench: drives loads, steps and way-count writes into the
// cache simulator and checks responses. Depends on oprc_pkg, oprc_if, scoreboard.
module tb_optimal_replacement_cache_sim;
   import oprc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct, recv_idle_pct;

   oprc_req_if req_bus();
   oprc_rsp_if rsp_bus();
   oprc_csr_if csr_bus();

   belady_scoreboard_type board = new();

   optimal_replacement_cache_sim dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stall, check accepted beats
   always @(negedge clock)
      rsp_bus.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock)
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_response({rsp_bus.outcome, rsp_bus.way_used, rsp_bus.access_index,
            rsp_bus.hit_count, rsp_bus.compulsory_count, rsp_bus.capacity_count,
            rsp_bus.trace_done});

   // Send one request beat with optional idle cycles first; valid stays up
   // until the next beat or the next drain
   task automatic send_beat(logic kind, logic [IN_ADDR_W-1:0] addr, logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind <= kind;
      req_bus.block_address <= addr;
      req_bus.start_new <= start;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(kind, addr, start);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (board.pending_reports.size() != 0) @(negedge clock);
      repeat (WAYS * 2 + TRACE_DEPTH + 20) @(negedge clock);
   endtask

   task automatic write_ways(logic [CFG_W-1:0] v);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= v;
      do @(posedge clock); while (!csr_bus.ready);
      board.set_ways(v);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // A trace with reuse from a small address pool, then stepped through
   task automatic run_trace(int unsigned len, int unsigned pool, bit extra_steps);
      logic [IN_ADDR_W-1:0] base;
      base = $urandom;
      for (int unsigned i = 0; i < len; i++)
         send_beat(KIND_LOAD, base ^ $urandom_range(pool - 1), i == 0);
      for (int unsigned i = 0; i < len + extra_steps; i++)
         send_beat(KIND_STEP, '0, 1'b0);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_LOAD;
      req_bus.block_address = '0;
      req_bus.start_new = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: step on empty trace, address extremes, loads after steps
      send_beat(KIND_STEP, '0, 1'b0);
      drain();
      write_ways(5'd2);
      send_beat(KIND_LOAD, 32'h0000_0000, 1'b1);
      send_beat(KIND_LOAD, 32'hFFFF_FFFF, 1'b0);
      send_beat(KIND_LOAD, 32'hAAAA_5555, 1'b0);
      send_beat(KIND_LOAD, 32'h0000_0000, 1'b0);
      send_beat(KIND_LOAD, 32'h5555_AAAA, 1'b0);
      repeat (3) send_beat(KIND_STEP, '0, 1'b0);
      send_beat(KIND_LOAD, 32'hFFFF_FFFF, 1'b0);
      send_beat(KIND_LOAD, 32'hAAAA_5555, 1'b0);
      repeat (5) send_beat(KIND_STEP, '0, 1'b0);
      drain();
      // Register out of range and lowered below fill level
      write_ways(5'd0);
      run_trace(6, 3, 1);
      drain();
      write_ways(5'd31);
      run_trace(20, 24, 1);
      drain();
      write_ways(5'd1);

      // Random phases with varying idling and way counts
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 79 : 0;
         recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 27 : 0;
         for (int t = 0; t < 4; t++) begin
            int unsigned len;
            drain();
            write_ways((t == 0) ? 5'd16 : (t == 1) ? 5'd1 : 5'($urandom_range(31)));
            len = $urandom_range(11, 5);
            run_trace(len, $urandom_range(12, 2), 1'($urandom_range(1)));
            if ($urandom_range(3) == 0)
               send_beat(KIND_LOAD, $urandom, 1'($urandom_range(1)));
         end
      end
      // Clear with a fresh trace, started without a drain first
      run_trace(10, 5, 1);
      drain();

      if (board.mismatches == 0 && board.pending_reports.size() == 0)
         $display("tb_optimal_replacement_cache_sim OK");
      else
         $display("tb_optimal_replacement_cache_sim NOT OK");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_optimal_replacement_cache_sim NOT OK");
      $finish;
   end
endmodule

// ===== filelist.f =====
sv/oprc_pkg.sv
sv/oprc_if.sv
sv/oprc_ram.sv
sv/oprc_cell.sv
sv/optimal_replacement_cache_sim.sv
tb/sv/oprc_scoreboard.sv
tb/sv/tb_optimal_replacement_cache_sim.sv
